>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the tone transmitter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define FSK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define FSK_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/fsk_pkg.sv
// ----------------------------------------------------------------------------
// fsk_pkg
// Types and register indexes shared by the tone transmitter modules.
// ----------------------------------------------------------------------------
package fsk_pkg;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 10;

  typedef logic [CfgIndexW-1:0] cfg_index_t;

  localparam cfg_index_t REG_HIGH_HALF   = 3'd0;
  localparam cfg_index_t REG_LOW_HALF    = 3'd1;
  localparam cfg_index_t REG_HIGH_CYCLES = 3'd2;
  localparam cfg_index_t REG_LOW_CYCLES  = 3'd3;
  localparam cfg_index_t REG_EVEN_ADDEND = 3'd4;
  localparam cfg_index_t REG_ODD_ADDEND  = 3'd5;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload;
  } item_t;

  typedef struct packed {
    logic tone_out;
    logic busy_res;
    logic frame_done;
    logic dropped;
  } result_t;

  typedef struct packed {
    logic [9:0] high_half_period;
    logic [9:0] low_half_period;
    logic [4:0] high_cycles;
    logic [4:0] low_cycles;
    logic [7:0] even_addend;
    logic [7:0] odd_addend;
  } cfg_t;

endpackage

>>> rtl/core/fsk_cfg_regs.sv
// ----------------------------------------------------------------------------
// fsk_cfg_regs
// Configuration register file; writes to unused indexes are ignored.
// ----------------------------------------------------------------------------
module fsk_cfg_regs (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  fsk_pkg::cfg_index_t   cfg_index,
  input  logic [fsk_pkg::CfgDataW-1:0] cfg_data,
  output fsk_pkg::cfg_t         cfg
);
  import fsk_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.high_half_period <= 10'd158;
      cfg.low_half_period  <= 10'd317;
      cfg.high_cycles      <= 5'd10;
      cfg.low_cycles       <= 5'd5;
      cfg.even_addend      <= 8'd64;
      cfg.odd_addend       <= 8'd32;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HIGH_HALF:   cfg.high_half_period <= cfg_data[9:0];
        REG_LOW_HALF:    cfg.low_half_period  <= cfg_data[9:0];
        REG_HIGH_CYCLES: cfg.high_cycles      <= cfg_data[4:0];
        REG_LOW_CYCLES:  cfg.low_cycles       <= cfg_data[4:0];
        REG_EVEN_ADDEND: cfg.even_addend      <= cfg_data[7:0];
        REG_ODD_ADDEND:  cfg.odd_addend       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/fsk_tone_core.sv
// ----------------------------------------------------------------------------
// fsk_tone_core
// Frame encoder and tone timing state; one accepted word updates the state per cycle, none while accept is low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fsk_tone_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  fsk_pkg::item_t    item,
  input  fsk_pkg::cfg_t     cfg,
  output fsk_pkg::result_t  res
);
  import fsk_pkg::*;

  logic [10:0] frame_shift, frame_shift_next;
  logic [3:0]  bits_left, bits_left_next;
  logic [9:0]  tick_count, tick_count_next;
  logic [5:0]  toggles_left, toggles_left_next;
  logic        pin_level, pin_level_next;
  logic        sending, sending_next;
  logic        done, drop;

  logic [7:0]  addend;
  logic [7:0]  msg;
  logic [10:0] frame_new;
  logic [10:0] frame_shifted;
  logic [9:0]  tick_dec;
  logic [5:0]  tog_dec;
  logic [3:0]  bits_dec;

  function automatic logic [9:0] half_for(input logic b, input cfg_t c);
    logic [9:0] h;
    h = b ? c.high_half_period : c.low_half_period;
    return (h == 10'd0) ? 10'd1 : h;
  endfunction

  function automatic logic [5:0] toggles_for(input logic b, input cfg_t c);
    logic [4:0] n;
    n = b ? c.high_cycles : c.low_cycles;
    if (n == 5'd0) n = 5'd1;
    return {n, 1'b0};
  endfunction

  // even popcount -> even addend
  assign addend        = (^item.payload) ? cfg.odd_addend : cfg.even_addend;
  assign msg           = item.payload + addend;
  assign frame_new     = {1'b1, 1'b1, msg, 1'b0};
  assign frame_shifted = {1'b0, frame_shift[10:1]};
  assign tick_dec      = tick_count - 10'd1;
  assign tog_dec       = toggles_left - 6'd1;
  assign bits_dec      = bits_left - 4'd1;

  always_comb begin
    frame_shift_next  = frame_shift;
    bits_left_next    = bits_left;
    tick_count_next   = tick_count;
    toggles_left_next = toggles_left;
    pin_level_next    = pin_level;
    sending_next      = sending;
    done              = 1'b0;
    drop              = 1'b0;
    if (item.kind) begin
      if (sending) begin
        drop = 1'b1;
      end else begin
        frame_shift_next  = frame_new;
        bits_left_next    = 4'd11;
        sending_next      = 1'b1;
        tick_count_next   = half_for(frame_new[0], cfg);
        toggles_left_next = toggles_for(frame_new[0], cfg);
      end
    end else if (sending) begin
      tick_count_next = tick_dec;
      if (tick_dec == 10'd0) begin
        pin_level_next    = ~pin_level;
        toggles_left_next = tog_dec;
        if (tog_dec == 6'd0) begin
          // bit finished: pin back to low, next frame bit
          pin_level_next   = 1'b0;
          frame_shift_next = frame_shifted;
          bits_left_next   = bits_dec;
          if (bits_dec == 4'd0) begin
            sending_next    = 1'b0;
            done            = 1'b1;
            tick_count_next = 10'd0;
          end else begin
            tick_count_next   = half_for(frame_shifted[0], cfg);
            toggles_left_next = toggles_for(frame_shifted[0], cfg);
          end
        end else begin
          tick_count_next = half_for(frame_shift[0], cfg);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_shift  <= '0;
      bits_left    <= '0;
      tick_count   <= '0;
      toggles_left <= '0;
      pin_level    <= 1'b0;
      sending      <= 1'b0;
    end else if (accept) begin
      frame_shift  <= frame_shift_next;
      bits_left    <= bits_left_next;
      tick_count   <= tick_count_next;
      toggles_left <= toggles_left_next;
      pin_level    <= pin_level_next;
      sending      <= sending_next;
    end
  end

  assign res.tone_out   = pin_level_next;
  assign res.busy_res   = sending_next;
  assign res.frame_done = done;
  assign res.dropped    = drop;

  `FSK_ASSERT(a_busy_bits, clk, rst, (sending == (bits_left != 4'd0)), "busy flag and bit count disagree")
  `FSK_ASSERT(a_idle_pin_low, clk, rst, (!sending |-> !pin_level), "pin high while idle")
  `FSK_ASSERT(a_drop_keeps_frame, clk, rst, (accept && item.kind && sending |=> $stable(frame_shift) && $stable(tick_count)), "dropped send changed the frame")

endmodule

>>> rtl/core/fsk_out_buf.sv
// ----------------------------------------------------------------------------
// fsk_out_buf
// Two-entry output register with skid slot for result words.
// ----------------------------------------------------------------------------
module fsk_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fsk_pkg::result_t  push_word,
  output logic              full,
  output logic              valid,
  input  logic              stall,
  output fsk_pkg::result_t  head
);
  import fsk_pkg::*;

  result_t    tail;
  logic [1:0] count;
  logic       pop;

  assign valid = (count != 2'd0);
  assign full  = (count == 2'd2);
  assign pop   = valid && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (count == 2'd0) head <= push_word;
        else               tail <= push_word;
      end
      2'b01: begin
        head <= tail;
      end
      2'b11: begin
        if (count == 2'd1) begin
          head <= push_word;
        end else begin
          head <= tail;
          tail <= push_word;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/fsk_serial_tone_transmitter.sv
// ----------------------------------------------------------------------------
// fsk_serial_tone_transmitter
// FSK serial transmitter: parity-adjusted byte sent as an 11-bit tone frame.
// ----------------------------------------------------------------------------
//   channel  | handshake               | word
//   ---------+-------------------------+---------------------------------------
//   item     | item_valid / item_stall | kind, payload (tick or byte to send)
//   result   | result_valid / result_stall | tone_out, busy_res, frame_done, dropped
//   cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One item word per cycle unless stalled; each yields one registered result word.
// The state update for a word is a single pass through the tone core.
// Results sit in a two-word output buffer; item_stall rises only when it is full.
// Reset (rst, synchronous) clears the frame state and loads register defaults.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module fsk_serial_tone_transmitter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  fsk_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output fsk_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  fsk_pkg::cfg_index_t           cfg_index,
  input  logic [fsk_pkg::CfgDataW-1:0]  cfg_data
);
  import fsk_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    accept;
  logic    full;

  assign item_stall = full;
  assign accept     = item_valid && !item_stall;

  fsk_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fsk_tone_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .cfg    (cfg),
    .res    (res)
  );

  fsk_out_buf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_word (res),
    .full      (full),
    .valid     (result_valid),
    .stall     (result_stall),
    .head      (result)
  );

endmodule

>>> tb/sv/fsk_serial_tone_transmitter_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fsk_serial_tone_transmitter_test
// Feeds tick and send words into the tone transmitter under varied register
// settings and handshake pressure. A local model of the parity addend, frame
// shifter and tone counters predicts each result word; the monitor compares.
// ----------------------------------------------------------------------------
module fsk_serial_tone_transmitter_test;
  import fsk_pkg::*;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_SEND = 1'b1;
  // indexes past the register file; writes there must be ignored
  localparam cfg_index_t REG_UNUSED_LO = 3'd6;
  localparam cfg_index_t REG_UNUSED_HI = 3'd7;
  localparam int HoldCycles = 80;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_stall;
  item_t               item = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  result_t             result;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_index_t          cfg_index = REG_HIGH_HALF;
  logic [CfgDataW-1:0] cfg_data = '0;

  fsk_serial_tone_transmitter uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // transmitter model state and register copy
  cfg_t        tone_cfg = '{high_half_period: 10'd158, low_half_period: 10'd317,
                            high_cycles: 5'd10, low_cycles: 5'd5,
                            even_addend: 8'd64, odd_addend: 8'd32};
  logic [10:0] tx_frame = '0;
  logic [3:0]  tx_bits_left = '0;
  logic [9:0]  tx_ticks = '0;
  logic [5:0]  tx_toggles = '0;
  logic        tx_pin = 1'b0;
  logic        tx_sending = 1'b0;

  item_t   pending_words[$];
  result_t tone_expect[$];
  int      queued_total = 0;
  int      failures = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_requests = 0;
  int      holds_served = 0;
  int      hold_left = 0;

  function automatic logic [9:0] half_of(logic b);
    logic [9:0] h;
    h = b ? tone_cfg.high_half_period : tone_cfg.low_half_period;
    return (h == 0) ? 10'd1 : h;
  endfunction

  function automatic logic [4:0] cycles_of(logic b);
    logic [4:0] c;
    c = b ? tone_cfg.high_cycles : tone_cfg.low_cycles;
    return (c == 0) ? 5'd1 : c;
  endfunction

  // two stop bits above the adjusted byte, start bit at the bottom
  function automatic logic [10:0] make_frame(logic [7:0] b);
    logic [7:0] msg;
    msg = b + ((^b) ? tone_cfg.odd_addend : tone_cfg.even_addend);
    return {2'b11, msg, 1'b0};
  endfunction

  function automatic void load_bit();
    tx_ticks   = half_of(tx_frame[0]);
    tx_toggles = {cycles_of(tx_frame[0]), 1'b0};
  endfunction

  // ticks needed to send a whole frame for b, started idle, under current registers
  function automatic int frame_ticks(logic [7:0] b);
    logic [10:0] f;
    int total;
    f = make_frame(b);
    total = 0;
    for (int i = 0; i < 11; i++)
      total += int'(half_of(f[i])) * 2 * int'(cycles_of(f[i]));
    return total;
  endfunction

  function automatic result_t transmit_step(item_t w);
    result_t r;
    r = '0;
    if (w.kind == KIND_SEND) begin
      if (tx_sending) begin
        r.dropped = 1'b1;
      end else begin
        tx_frame     = make_frame(w.payload);
        tx_bits_left = 4'd11;
        tx_sending   = 1'b1;
        load_bit();
      end
    end else if (tx_sending) begin
      tx_ticks = tx_ticks - 10'd1;
      if (tx_ticks == 0) begin
        tx_pin     = ~tx_pin;
        tx_toggles = tx_toggles - 6'd1;
        if (tx_toggles == 0) begin
          tx_pin       = 1'b0;
          tx_frame     = tx_frame >> 1;
          tx_bits_left = tx_bits_left - 4'd1;
          if (tx_bits_left == 0) begin
            tx_sending   = 1'b0;
            r.frame_done = 1'b1;
            tx_ticks     = '0;
          end else begin
            load_bit();
          end
        end else begin
          tx_ticks = half_of(tx_frame[0]);
        end
      end
    end
    r.tone_out = tx_pin;
    r.busy_res = tx_sending;
    return r;
  endfunction

  // sender: predicts on acceptance, then offers the next word or idles
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall)
        tone_expect.push_back(transmit_step(item));
      if (!item_valid || !item_stall) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          item       <= pending_words.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left    <= HoldCycles;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (tone_expect.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result word %b arrived with nothing expected", $time, result);
      end else begin
        want = tone_expect.pop_front();
        if (result.tone_out !== want.tone_out || result.busy_res !== want.busy_res ||
            result.frame_done !== want.frame_done || result.dropped !== want.dropped) begin
          failures++;
          if (failures <= 10)
            $display({"%0t: expected tone_out=%b busy_res=%b frame_done=%b dropped=%b,",
                      " got %b %b %b %b"},
                     $time, want.tone_out, want.busy_res, want.frame_done, want.dropped,
                     result.tone_out, result.busy_res, result.frame_done, result.dropped);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic queue_ticks(int n);
    for (int i = 0; i < n; i++) begin
      pending_words.push_back(item_t'{kind: KIND_TICK, payload: 8'($urandom)});
      queued_total++;
    end
  endtask

  task automatic queue_send(logic [7:0] b);
    pending_words.push_back(item_t'{kind: KIND_SEND, payload: b});
    queued_total++;
  endtask

  task automatic queue_frame(logic [7:0] b, int extra);
    queue_send(b);
    queue_ticks(frame_ticks(b) + extra);
  endtask

  task automatic wait_quiet();
    do @(posedge clk);
    while (pending_words.size() != 0 || item_valid || tone_expect.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(cfg_index_t idx, logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
    unique case (idx)
      REG_HIGH_HALF:   tone_cfg.high_half_period = data[9:0];
      REG_LOW_HALF:    tone_cfg.low_half_period  = data[9:0];
      REG_HIGH_CYCLES: tone_cfg.high_cycles      = data[4:0];
      REG_LOW_CYCLES:  tone_cfg.low_cycles       = data[4:0];
      REG_EVEN_ADDEND: tone_cfg.even_addend      = data[7:0];
      REG_ODD_ADDEND:  tone_cfg.odd_addend       = data[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [9:0] hi_half, lo_half, hi_cyc, lo_cyc,
                                even_add, odd_add);
    put_reg(REG_HIGH_HALF, hi_half);
    put_reg(REG_LOW_HALF, lo_half);
    put_reg(REG_HIGH_CYCLES, hi_cyc);
    put_reg(REG_LOW_CYCLES, lo_cyc);
    put_reg(REG_EVEN_ADDEND, even_add);
    put_reg(REG_ODD_ADDEND, odd_add);
    put_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI, 10'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // keep ticking until the frame in flight completes
  task automatic finish_frame();
    while (tx_sending) begin
      queue_ticks(16);
      wait_quiet();
    end
  endtask

  // mostly whole frames with random bytes; some cut short or overrun,
  // and stray sends land mid-frame to be dropped
  task automatic random_traffic(int count);
    int stop_at;
    int span;
    logic [7:0] b;
    stop_at = queued_total + count;
    while (queued_total < stop_at) begin
      queue_ticks($urandom_range(0, 2));
      b = 8'($urandom);
      queue_send(b);
      span = frame_ticks(b);
      case ($urandom_range(0, 9))
        0: span = $urandom_range(0, span - 1);
        1: span += $urandom_range(1, 4);
        default: ;
      endcase
      for (int i = 0; i < span; i++) begin
        if ($urandom_range(0, 19) == 0)
          queue_send(8'($urandom));
        queue_ticks(1);
      end
    end
  endtask

  initial begin
    int idle_plan[4];
    int stall_plan[4];
    idle_plan  = '{0, 66, 0, 20};
    stall_plan = '{0, 0, 66, 20};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset registers: idle ticks, a send, then collisions while busy
    queue_ticks(2);
    queue_send(8'h00);
    queue_send(8'hFF);
    queue_ticks(3);
    queue_send(8'h01);
    wait_quiet();

    // shorten the tones while that frame is still going out
    apply_settings(10'd1, 10'd2, 10'd1, 10'd2, 10'd0, 10'd255);
    finish_frame();
    queue_frame(8'h80, 1);
    queue_frame(8'hFF, 0);
    wait_quiet();

    // zero periods and counts behave as one
    apply_settings(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
    queue_frame(8'h55, 2);
    wait_quiet();

    // longest high period, largest counts and addends, then cut back mid-frame
    apply_settings(10'd1023, 10'd3, 10'd31, 10'd31, 10'd255, 10'd255);
    queue_send(8'hFF);
    queue_ticks(40);
    wait_quiet();
    apply_settings(10'd1, 10'd1, 10'd1, 10'd1, 10'd64, 10'd32);
    finish_frame();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  <= idle_plan[p];
      recv_stall_pct <= stall_plan[p];
      apply_settings(10'($urandom_range(0, 2)), 10'($urandom_range(0, 2)),
                     {5'($urandom), 5'($urandom_range(0, 2))},
                     {5'($urandom), 5'($urandom_range(0, 2))},
                     {2'($urandom), 8'($urandom)}, {2'($urandom), 8'($urandom)});
      random_traffic(60);
      // back up the output while the sender keeps offering words
      if (p == 0)
        hold_requests <= hold_requests + 1;
      wait_quiet();
    end

    if (failures == 0 && tone_expect.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
